FILE: hdl/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg
// Types and codes shared by the indexed list store modules.
// ----------------------------------------------------------------------------
package ils_pkg;

    typedef enum logic [2:0] {
        REQ_APPEND = 3'd0,
        REQ_POP    = 3'd1,
        REQ_REMOVE = 3'd2,
        REQ_GET    = 3'd3,
        REQ_SET    = 3'd4,
        REQ_INSERT = 3'd5
    } req_code_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_SHIFT,
        S_DRAIN,
        S_FILL,
        S_PUT,
        S_DONE
    } state_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_APPEND,
        DP_POP,
        DP_GET,
        DP_SET,
        DP_REMOVE_END,
        DP_DN_INIT,
        DP_UP_INIT,
        DP_FILL_INIT,
        DP_SHIFT,
        DP_DRAIN,
        DP_PUT,
        DP_FILL,
        DP_RDDATA,
        DP_OUT
    } dp_op_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  position;
        logic [63:0] word_in;
    } ils_req_t;

    typedef struct packed {
        logic [63:0] word_out;
        logic [7:0]  position_out;
        logic [1:0]  status;
        logic [8:0]  count_after;
    } ils_rsp_t;

    typedef struct packed {
        dp_op_t op;
        logic   check;
    } ils_cmd_t;

    typedef struct packed {
        logic [2:0] req_type;
        status_t    check;
        logic       pos_lt_count;
        logic       pos_eq_count;
        logic       pos_last;
        logic       shift_last;
        logic       fill_last;
        logic       dir_up;
        logic       out_free;
    } ils_stat_t;

endpackage

FILE: hdl/ils_ram.sv
// ----------------------------------------------------------------------------
// ils_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ils_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/ils_datapath.sv
// ----------------------------------------------------------------------------
// ils_datapath
// Request registers, word count, shift pipeline, word memory and result
// register of the indexed list store.
// ----------------------------------------------------------------------------
module ils_datapath
    import ils_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  logic      clk,
    input  logic      rst_n,
    input  ils_req_t  req_data,
    input  ils_cmd_t  cmd,
    output ils_stat_t stat,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output ils_rsp_t  rsp_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int W  = (CW > 9) ? CW : 9;

    logic [CW-1:0] count_reg, count_next;
    logic [2:0]    req_type_reg, req_type_next;
    logic [7:0]    pos_reg, pos_next;
    logic [63:0]   word_reg, word_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          dir_up_reg, dir_up_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] wr_addr_reg, wr_addr_next;
    logic [63:0]   res_word_reg, res_word_next;
    logic [7:0]    res_wpos_reg, res_wpos_next;
    status_t       res_status_reg, res_status_next;
    logic          rsp_valid_reg, rsp_valid_next;
    ils_rsp_t      rsp_data_reg, rsp_data_next;

    logic [W-1:0]  cnt_w, pos_w, idx_w, cap_w;
    logic [W-1:0]  cnt_p1, cnt_m1, pos_p1, idx_p1, idx_m1;
    status_t       check;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [63:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [63:0]   ram_rdata;

    assign cnt_w  = W'(count_reg);
    assign pos_w  = W'(pos_reg);
    assign idx_w  = W'(idx_reg);
    assign cap_w  = W'(CAPACITY);
    assign cnt_p1 = cnt_w + W'(1);
    assign cnt_m1 = cnt_w - W'(1);
    assign pos_p1 = pos_w + W'(1);
    assign idx_p1 = idx_w + W'(1);
    assign idx_m1 = idx_w - W'(1);

    // request checks against the current count
    always_comb
    begin
        check = ST_OK;
        case (req_type_reg)
            REQ_APPEND:
            begin
                if (cnt_w >= cap_w)
                begin
                    check = ST_FULL;
                end
            end
            REQ_POP:
            begin
                if (cnt_w == '0)
                begin
                    check = ST_RANGE;
                end
            end
            REQ_REMOVE, REQ_GET, REQ_SET:
            begin
                if (pos_w >= cnt_w)
                begin
                    check = ST_RANGE;
                end
            end
            REQ_INSERT:
            begin
                if (pos_w < cnt_w)
                begin
                    if (cnt_w >= cap_w)
                    begin
                        check = ST_FULL;
                    end
                end
                else if (pos_w >= cap_w)
                begin
                    check = ST_FULL;
                end
            end
            default:
            begin
                check = ST_RANGE;
            end
        endcase
    end

    always_comb
    begin
        stat.req_type     = req_type_reg;
        stat.check        = check;
        stat.pos_lt_count = (pos_w < cnt_w);
        stat.pos_eq_count = (pos_w == cnt_w);
        stat.pos_last     = (pos_p1 == cnt_w);
        stat.shift_last   = dir_up_reg ? (idx_w == pos_w) : (idx_p1 == cnt_w);
        stat.fill_last    = (idx_p1 == pos_w);
        stat.dir_up       = dir_up_reg;
        stat.out_free     = !rsp_valid_reg || rsp_ready;
    end

    always_comb
    begin
        count_next      = count_reg;
        req_type_next   = req_type_reg;
        pos_next        = pos_reg;
        word_next       = word_reg;
        idx_next        = idx_reg;
        dir_up_next     = dir_up_reg;
        pend_next       = pend_reg;
        wr_addr_next    = wr_addr_reg;
        res_word_next   = res_word_reg;
        res_wpos_next   = res_wpos_reg;
        res_status_next = res_status_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        rsp_data_next   = rsp_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = wr_addr_reg;
        ram_wdata       = ram_rdata;
        ram_raddr       = idx_reg[AW-1:0];

        case (cmd.op)
            DP_LOAD:
            begin
                req_type_next = req_data.req_type;
                pos_next      = req_data.position;
                word_next     = req_data.word_in;
                res_word_next = '0;
                res_wpos_next = '0;
            end
            DP_APPEND:
            begin
                ram_we        = 1'b1;
                ram_waddr     = cnt_w[AW-1:0];
                ram_wdata     = word_reg;
                res_wpos_next = cnt_w[7:0];
                count_next    = cnt_p1[CW-1:0];
            end
            DP_POP:
            begin
                ram_raddr  = cnt_m1[AW-1:0];
                count_next = cnt_m1[CW-1:0];
            end
            DP_GET:
            begin
                ram_raddr = pos_w[AW-1:0];
            end
            DP_SET:
            begin
                ram_we    = 1'b1;
                ram_waddr = pos_w[AW-1:0];
                ram_wdata = word_reg;
            end
            DP_REMOVE_END:
            begin
                count_next = cnt_m1[CW-1:0];
            end
            DP_DN_INIT:
            begin
                idx_next    = pos_p1[CW-1:0];
                dir_up_next = 1'b0;
                pend_next   = 1'b0;
            end
            DP_UP_INIT:
            begin
                idx_next    = cnt_m1[CW-1:0];
                dir_up_next = 1'b1;
                pend_next   = 1'b0;
            end
            DP_FILL_INIT:
            begin
                idx_next = count_reg;
            end
            DP_SHIFT:
            begin
                // write the word read last cycle, read the next one
                ram_we    = pend_reg;
                ram_raddr = idx_reg[AW-1:0];
                pend_next = 1'b1;
                if (dir_up_reg)
                begin
                    wr_addr_next = idx_p1[AW-1:0];
                    idx_next     = idx_m1[CW-1:0];
                end
                else
                begin
                    wr_addr_next = idx_m1[AW-1:0];
                    idx_next     = idx_p1[CW-1:0];
                end
            end
            DP_DRAIN:
            begin
                ram_we    = pend_reg;
                pend_next = 1'b0;
                if (!dir_up_reg)
                begin
                    count_next = cnt_m1[CW-1:0];
                end
            end
            DP_PUT:
            begin
                ram_we        = 1'b1;
                ram_waddr     = pos_w[AW-1:0];
                ram_wdata     = word_reg;
                res_wpos_next = pos_reg;
                if (pos_w >= cnt_w)
                begin
                    count_next = pos_p1[CW-1:0];
                end
                else
                begin
                    count_next = cnt_p1[CW-1:0];
                end
            end
            DP_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_w[AW-1:0];
                ram_wdata = '0;
                idx_next  = idx_p1[CW-1:0];
            end
            DP_RDDATA:
            begin
                res_word_next = ram_rdata;
            end
            DP_OUT:
            begin
                rsp_valid_next             = 1'b1;
                rsp_data_next.word_out     = res_word_reg;
                rsp_data_next.position_out = res_wpos_reg;
                rsp_data_next.status       = res_status_reg;
                rsp_data_next.count_after  = cnt_w[8:0];
            end
            default:
            begin
            end
        endcase

        if (cmd.check)
        begin
            res_status_next = check;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_type_reg   <= req_type_next;
        pos_reg        <= pos_next;
        word_reg       <= word_next;
        idx_reg        <= idx_next;
        dir_up_reg     <= dir_up_next;
        wr_addr_reg    <= wr_addr_next;
        res_word_reg   <= res_word_next;
        res_wpos_reg   <= res_wpos_next;
        res_status_reg <= res_status_next;
        rsp_data_reg   <= rsp_data_next;
    end

    ils_ram #(
        .WIDTH (64),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

FILE: hdl/ils_ctrl.sv
// ----------------------------------------------------------------------------
// ils_ctrl
// Request sequencer of the indexed list store: decodes a request and steps
// the datapath through reads, shifts, zero fill and result hand-off.
// ----------------------------------------------------------------------------
module ils_ctrl
    import ils_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  ils_stat_t stat,
    output ils_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        cmd.op     = DP_NOP;
        cmd.check  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.op     = DP_LOAD;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.check  = 1'b1;
                state_next = S_DONE;
                if (stat.check == ST_OK)
                begin
                    case (stat.req_type)
                        REQ_APPEND:
                        begin
                            cmd.op = DP_APPEND;
                        end
                        REQ_POP:
                        begin
                            cmd.op     = DP_POP;
                            state_next = S_RDWAIT;
                        end
                        REQ_GET:
                        begin
                            cmd.op     = DP_GET;
                            state_next = S_RDWAIT;
                        end
                        REQ_SET:
                        begin
                            cmd.op = DP_SET;
                        end
                        REQ_REMOVE:
                        begin
                            if (stat.pos_last)
                            begin
                                cmd.op = DP_REMOVE_END;
                            end
                            else
                            begin
                                cmd.op     = DP_DN_INIT;
                                state_next = S_SHIFT;
                            end
                        end
                        REQ_INSERT:
                        begin
                            if (stat.pos_lt_count)
                            begin
                                cmd.op     = DP_UP_INIT;
                                state_next = S_SHIFT;
                            end
                            else if (stat.pos_eq_count)
                            begin
                                cmd.op = DP_PUT;
                            end
                            else
                            begin
                                cmd.op     = DP_FILL_INIT;
                                state_next = S_FILL;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RDWAIT:
            begin
                cmd.op     = DP_RDDATA;
                state_next = S_DONE;
            end
            S_SHIFT:
            begin
                cmd.op = DP_SHIFT;
                if (stat.shift_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                cmd.op     = DP_DRAIN;
                state_next = stat.dir_up ? S_PUT : S_DONE;
            end
            S_FILL:
            begin
                cmd.op = DP_FILL;
                if (stat.fill_last)
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                cmd.op     = DP_PUT;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = DP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/indexed_list_store.sv
// ----------------------------------------------------------------------------
// indexed_list_store
// Bounded ordered list of 64-bit words: append, pop, remove, get, set and
// insert at an index, one request at a time.
// ----------------------------------------------------------------------------
// Requests enter on req_valid/req_ready/req_data and each gives exactly one
// response on rsp_valid/rsp_ready/rsp_data, in order.
// A request is taken only while the sequencer is idle; it holds one request
// at a time. The response sits in an output register, so the next request
// is taken while an earlier response still waits for rsp_ready.
// Append, set, get, pop and rejected requests move no words; remove and
// insert inside the list shift the tail of the list, and insert past the
// end first fills the gap up to the index with zeros. The words move one
// per cycle through the single write port of the word memory.
// When rsp_ready is low the finished response is held and the sequencer
// waits before loading a new one.
// Reset empties the list; the memory itself is not cleared and needs no
// clearing pass.
// ----------------------------------------------------------------------------
module indexed_list_store
    import ils_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  ils_req_t req_data,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output ils_rsp_t rsp_data
);

    ils_cmd_t  cmd;
    ils_stat_t stat;

    ils_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ils_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks indexed_list_store against a behavioral list model kept in the bench.
// Each accepted request is applied to that model, and the response it
// predicts is queued. Every response from the block is compared field by
// field with the oldest queued prediction. The stimulus is a directed opening
// (empty list, growing past the end with zero fill, full list, last index,
// unused codes) and then random request streams, each steered toward a
// target list length. The sender works in bursts, and the receiver stalls,
// including long hold-offs that back up the request side.
// ----------------------------------------------------------------------------
module testbench;
    import ils_pkg::*;

    localparam int CAPACITY = 256;
    localparam int LIVE = 0;
    localparam int PLAN = 1;
    localparam logic [2:0] REQ_SPARE_LO = 3'd6;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;
    localparam int RANDOM_REQS = 800;
    localparam int HOLD_CYCLES = 300;

    typedef enum int {
        PACE_FREE,
        PACE_COIN,
        PACE_MOSTLY,
        PACE_MASK
    } pace_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    ils_req_t req_data = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    ils_rsp_t rsp_data;

    // two copies of the list: one follows accepted requests, one plans stimulus
    logic [63:0] list_words [2][CAPACITY];
    int unsigned list_len [2] = '{0, 0};

    ils_req_t req_backlog [$];
    ils_rsp_t due_rsps [$];

    logic  req_fired = 1'b0;
    int    burst_left = 8;
    int    gap_left = 0;
    int    accepted_total = 0;
    int    hold_left = 0;
    int    holds_done = 0;
    int    mode_left = 0;
    pace_t pace_mode = PACE_FREE;
    logic [15:0] pace_mask = '1;
    int    error_count = 0;
    int    rsp_total = 0;
    int    n_ok = 0;
    int    n_range = 0;
    int    n_full = 0;
    int    n_shift = 0;
    int    max_len = 0;

    indexed_list_store #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req_data(req_data),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp_data(rsp_data)
    );

    always #6 clk = ~clk;

    function automatic ils_rsp_t list_apply(input int cp, input ils_req_t rq);
        ils_rsp_t    rs;
        int unsigned n;
        int unsigned p;
        int unsigned i;
        rs = '0;
        rs.status = ST_OK;
        n = list_len[cp];
        p = rq.position;
        case (rq.req_type)
            REQ_APPEND:
                if (n >= CAPACITY)
                begin
                    rs.status = ST_FULL;
                end
                else
                begin
                    list_words[cp][n] = rq.word_in;
                    rs.position_out = 8'(n);
                    n++;
                end
            REQ_POP:
                if (n == 0)
                begin
                    rs.status = ST_RANGE;
                end
                else
                begin
                    n--;
                    rs.word_out = list_words[cp][n];
                end
            REQ_REMOVE:
                if (p >= n)
                begin
                    rs.status = ST_RANGE;
                end
                else
                begin
                    for (i = p; i + 1 < n; i++)
                        list_words[cp][i] = list_words[cp][i + 1];
                    n--;
                end
            REQ_GET:
                if (p >= n)
                    rs.status = ST_RANGE;
                else
                    rs.word_out = list_words[cp][p];
            REQ_SET:
                if (p >= n)
                    rs.status = ST_RANGE;
                else
                    list_words[cp][p] = rq.word_in;
            REQ_INSERT:
                if (p < n)
                begin
                    if (n >= CAPACITY)
                    begin
                        rs.status = ST_FULL;
                    end
                    else
                    begin
                        for (i = n; i > p; i--)
                            list_words[cp][i] = list_words[cp][i - 1];
                        list_words[cp][p] = rq.word_in;
                        n++;
                        rs.position_out = 8'(p);
                    end
                end
                else if (p + 1 > CAPACITY)
                begin
                    rs.status = ST_FULL;
                end
                else
                begin
                    for (i = n; i < p; i++)
                        list_words[cp][i] = '0;
                    list_words[cp][p] = rq.word_in;
                    n = p + 1;
                    rs.position_out = 8'(p);
                end
            default:
                rs.status = ST_RANGE;
        endcase
        list_len[cp] = n;
        rs.count_after = 9'(n);
        return rs;
    endfunction

    function automatic logic [63:0] rand_word();
        int k;
        k = $urandom_range(0, 15);
        if (k == 0)
            return '0;
        else if (k == 1)
            return '1;
        else
            return {$urandom, $urandom};
    endfunction

    function automatic int pick_index(input int n);
        return (n == 0) ? 0 : $urandom_range(0, n - 1);
    endfunction

    function automatic int past_end(input int n);
        int p;
        p = n + $urandom_range(0, 3);
        return (p > 255) ? 255 : p;
    endfunction

    task automatic queue_request(input logic [2:0] code, input int pos,
                                 input logic [63:0] w);
        ils_req_t rq;
        rq.req_type = code;
        rq.position = 8'(pos);
        rq.word_in = w;
        void'(list_apply(PLAN, rq));
        req_backlog.push_back(rq);
    endtask

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            error_count++;
        end
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else if (!req_valid || req_fired)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                req_valid <= 1'b0;
            end
            else if (req_backlog.size() != 0)
            begin
                req_data <= req_backlog.pop_front();
                req_valid <= 1'b1;
                if (burst_left > 1)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // response pacing
    always @(negedge clk)
    begin : rsp_pace
        logic go;
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else
        begin
            if (hold_left == 0 && holds_done < 2 &&
                accepted_total >= 200 + 400 * holds_done)
            begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (mode_left == 0)
            begin
                pace_mode = pace_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 80);
                pace_mask = 16'($urandom);
            end
            mode_left--;
            case (pace_mode)
                PACE_FREE:   go = 1'b1;
                PACE_COIN:   go = 1'($urandom_range(0, 1));
                PACE_MOSTLY: go = ($urandom_range(0, 7) != 0);
                default:     go = pace_mask[mode_left % 16];
            endcase
            if (hold_left > 0)
            begin
                hold_left--;
                go = 1'b0;
            end
            rsp_ready <= go;
        end
    end

    // prediction and response check
    always @(posedge clk)
    begin : rsp_check
        ils_rsp_t want;
        if (!rst_n)
        begin
            req_fired = 1'b0;
        end
        else
        begin
            req_fired = req_valid && req_ready;
            if (req_fired)
            begin
                want = list_apply(LIVE, req_data);
                due_rsps.push_back(want);
                accepted_total++;
                case (want.status)
                    ST_OK:    n_ok++;
                    ST_RANGE: n_range++;
                    default:  n_full++;
                endcase
                if (want.status == ST_OK &&
                    (req_data.req_type == REQ_REMOVE || req_data.req_type == REQ_INSERT))
                    n_shift++;
                if (int'(want.count_after) > max_len)
                    max_len = int'(want.count_after);
            end
            if (rsp_valid && rsp_ready)
            begin
                rsp_total++;
                if (due_rsps.size() == 0)
                begin
                    $display("%0t: response mismatch, expected none, actual %0h",
                             $time, rsp_data);
                    error_count++;
                end
                else
                begin
                    want = due_rsps.pop_front();
                    check_field("word_out", want.word_out, rsp_data.word_out);
                    check_field("position_out", 64'(want.position_out),
                                64'(rsp_data.position_out));
                    check_field("status", 64'(want.status), 64'(rsp_data.status));
                    check_field("count_after", 64'(want.count_after),
                                64'(rsp_data.count_after));
                end
            end
        end
    end

    initial
    begin : stimulus
        int   targets [4];
        int   target;
        int   n;
        int   k;
        int   sel;
        logic grow;
        targets = '{4, 16, 64, 256};
        target = 16;

        // empty list, growth, zero fill, full list, last index, spare codes
        queue_request(REQ_POP, 0, '1);
        queue_request(REQ_GET, 0, '0);
        queue_request(REQ_REMOVE, 0, '0);
        queue_request(REQ_SET, 0, '1);
        queue_request(REQ_APPEND, 255, '0);
        queue_request(REQ_APPEND, 0, '1);
        queue_request(REQ_INSERT, 0, 64'h0123_4567_89ab_cdef);
        queue_request(REQ_INSERT, 5, 64'hfedc_ba98_7654_3210);
        queue_request(REQ_GET, 4, '0);
        queue_request(REQ_GET, 5, '0);
        queue_request(REQ_SET, 5, '1);
        queue_request(REQ_REMOVE, 0, '0);
        queue_request(REQ_REMOVE, 4, '0);
        queue_request(REQ_GET, 4, '0);
        queue_request(REQ_SET, 200, '1);
        queue_request(REQ_SPARE_LO, 1, '1);
        queue_request(REQ_SPARE_HI, 255, '1);
        queue_request(REQ_POP, 0, '0);
        queue_request(REQ_INSERT, 255, 64'h8000_0000_0000_0001);
        queue_request(REQ_APPEND, 0, '1);
        queue_request(REQ_INSERT, 10, '1);
        queue_request(REQ_INSERT, 255, '1);
        queue_request(REQ_GET, 255, '0);
        queue_request(REQ_REMOVE, 255, '0);
        queue_request(REQ_REMOVE, 0, '0);

        for (int r = 0; r < RANDOM_REQS; r++)
        begin
            if (r % 100 == 0)
                target = targets[$urandom_range(0, 3)];
            n = list_len[PLAN];
            grow = (n < target);
            k = $urandom_range(0, 99);
            sel = $urandom_range(0, 9);
            if (k < 6)
            begin
                queue_request(3'($urandom_range(0, 7)), $urandom_range(0, 255), rand_word());
            end
            else if (grow)
            begin
                case (sel)
                    0, 1, 2, 3: queue_request(REQ_APPEND, $urandom_range(0, 255), rand_word());
                    4, 5:       queue_request(REQ_INSERT, pick_index(n), rand_word());
                    6:          queue_request(REQ_INSERT, past_end(n), rand_word());
                    7:          queue_request(REQ_GET, pick_index(n), rand_word());
                    8:          queue_request(REQ_SET, pick_index(n), rand_word());
                    default:    queue_request(REQ_POP, $urandom_range(0, 255), rand_word());
                endcase
            end
            else
            begin
                case (sel)
                    0, 1, 2: queue_request(REQ_REMOVE, pick_index(n), rand_word());
                    3, 4:    queue_request(REQ_POP, $urandom_range(0, 255), rand_word());
                    5:       queue_request(REQ_GET, pick_index(n), rand_word());
                    6:       queue_request(REQ_SET, pick_index(n), rand_word());
                    7:       queue_request(REQ_APPEND, $urandom_range(0, 255), rand_word());
                    8:       queue_request(REQ_INSERT, pick_index(n), rand_word());
                    default: queue_request(3'($urandom_range(2, 4)), past_end(n), rand_word());
                endcase
            end
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (req_backlog.size() != 0 || req_valid)
            @(posedge clk);
        while (due_rsps.size() != 0)
            @(posedge clk);
        repeat (CAPACITY + 40) @(posedge clk);

        $display("run covered %0d requests, %0d responses: %0d ok, %0d out of range, %0d full",
                 accepted_total, rsp_total, n_ok, n_range, n_full);
        $display("%0d shifting inserts or removes, longest list %0d words, %0d receiver hold-offs",
                 n_shift, max_len, holds_done);
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    initial
    begin : watchdog
        #(12 * 1000000);
        $display("testbench: done, errors");
        $finish;
    end

endmodule
